FILE: design/tem_pkg.sv
// shared types, codes and helpers for the ticket extraction monitor
`default_nettype none
package tem_pkg;

  localparam int TIMER_BITS = 27;
  localparam int CFG_W      = 27;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [CFG_W-1:0]      cfg_t;

  localparam timer_t TIMER_MAX = '1;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_POLL  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [2:0] PH_IDLE           = 3'd0;
  localparam logic [2:0] PH_WAIT_SPOOL     = 3'd1;
  localparam logic [2:0] PH_SPOOL          = 3'd2;
  localparam logic [2:0] PH_WAIT_SPOOL_END = 3'd3;
  localparam logic [2:0] PH_WAIT_TICKET    = 3'd4;
  localparam logic [2:0] PH_CHECK          = 3'd5;

  localparam logic [1:0] OUT_EXTRACTED = 2'd0;
  localparam logic [1:0] OUT_TIMEOUT   = 2'd1;
  localparam logic [1:0] OUT_ERROR     = 2'd2;

  localparam int SPOOL_BIT  = 2;
  localparam int TICKET_BIT = 5;

  localparam timer_t LIMIT_WAIT_SPOOL  = TIMER_BITS'(1 * 1000);
  localparam timer_t LIMIT_SPOOL_END   = TIMER_BITS'(60 * 1000);
  localparam timer_t LIMIT_WAIT_TICKET = TIMER_BITS'(5 * 1000);

  localparam cfg_t CFG_RESET = CFG_W'(5000);

  typedef struct packed {
    logic [1:0] operation;
    logic       first_page;
    logic [7:0] status_byte_two;
    logic [7:0] status_byte_three;
    logic       read_ok;
  } item_t;

  typedef struct packed {
    logic [2:0] phase;
    timer_t     elapsed;
    timer_t     limit;
  } state_t;

  typedef struct packed {
    logic       done_res;
    logic [1:0] outcome;
    logic [2:0] phase;
  } result_t;

  // clamp a programmed timeout to the counter range
  function automatic timer_t cap_limit(input cfg_t v);
    logic [32:0] vx;
    logic [32:0] mx;
    vx = 33'(v);
    mx = 33'(TIMER_MAX);
    return (vx > mx) ? TIMER_MAX : TIMER_BITS'(v);
  endfunction

endpackage
`default_nettype wire

FILE: design/tem_next.sv
// next phase, timer and result for one item
`default_nettype none
module tem_next (
  input  wire tem_pkg::item_t   item,
  input  wire tem_pkg::state_t  cur,
  input  wire tem_pkg::cfg_t    extraction_timeout_ms,
  output tem_pkg::state_t       nxt,
  output tem_pkg::result_t      res
);
  import tem_pkg::*;

  logic       spool;
  logic       ticket;
  logic       fin;
  logic       stop;
  logic [1:0] how;
  timer_t     check_limit;

  assign spool       = item.status_byte_three[SPOOL_BIT];
  assign ticket      = item.status_byte_two[TICKET_BIT];
  assign check_limit = cap_limit(extraction_timeout_ms);

  always_comb begin
    nxt  = cur;
    fin  = 1'b0;
    stop = 1'b0;
    how  = OUT_EXTRACTED;
    case (item.operation)
      OP_START: begin
        if (!item.read_ok) begin
          fin = 1'b1;
          how = OUT_ERROR;
        end else if (item.first_page) begin
          nxt = '{phase: PH_CHECK, elapsed: '0, limit: check_limit};
        end else if (spool) begin
          nxt = '{phase: PH_SPOOL, elapsed: '0, limit: LIMIT_SPOOL_END};
        end else begin
          nxt = '{phase: PH_WAIT_SPOOL, elapsed: '0, limit: LIMIT_WAIT_SPOOL};
        end
      end
      OP_POLL: begin
        if (cur.phase != PH_IDLE) begin
          if (!item.read_ok) begin
            fin = 1'b1;
            how = OUT_ERROR;
          end else begin
            case (cur.phase)
              PH_WAIT_SPOOL: begin
                if (spool) nxt = '{phase: PH_SPOOL, elapsed: '0, limit: LIMIT_SPOOL_END};
              end
              PH_SPOOL, PH_WAIT_SPOOL_END: begin
                nxt.phase = PH_WAIT_SPOOL_END;
                if (!spool) begin
                  nxt = '{phase: PH_WAIT_TICKET, elapsed: '0, limit: LIMIT_WAIT_TICKET};
                end
              end
              PH_WAIT_TICKET: begin
                if (ticket) nxt = '{phase: PH_CHECK, elapsed: '0, limit: check_limit};
              end
              PH_CHECK: begin
                if (!ticket) begin
                  fin  = 1'b1;
                  stop = 1'b1;
                end
              end
              default: begin
                // unused phase codes drop back to idle without reporting done
                nxt.phase   = PH_IDLE;
                nxt.elapsed = '0;
                stop        = 1'b1;
              end
            endcase
            if (!stop && (nxt.elapsed > nxt.limit)) begin
              if ((nxt.phase == PH_WAIT_SPOOL) || (nxt.phase == PH_WAIT_TICKET)) begin
                nxt = '{phase: PH_CHECK, elapsed: '0, limit: check_limit};
              end else begin
                fin = 1'b1;
                how = OUT_TIMEOUT;
              end
            end
          end
        end
      end
      OP_TICK: begin
        if ((cur.phase != PH_IDLE) && (cur.elapsed != TIMER_MAX)) begin
          nxt.elapsed = cur.elapsed + TIMER_BITS'(1);
        end
      end
      default: ;
    endcase
    if (fin) begin
      nxt.phase   = PH_IDLE;
      nxt.elapsed = '0;
    end
    res.done_res = fin;
    res.outcome  = fin ? how : OUT_EXTRACTED;
    res.phase    = nxt.phase;
  end

endmodule
`default_nettype wire

FILE: design/ticket_extraction_monitor_top.sv
// top level: input register, phase and timer state, result register
`default_nettype none
// Ticket extraction monitor. Takes one item per clock: start, status poll or
// millisecond tick. Each item gives exactly one result: it is captured in the
// input register, and when it advances the phase machine and the saturating
// elapsed counter update from it in the same cycle that the result is written
// to the output register. The two stages move independently, so a new item
// is taken every cycle as long as results are drained; a stalled output holds
// one result and one item before in_ready drops. The extraction timeout
// register resets to 5000 ms; the user must write it through the cfg port only
// while no item is in flight, and the block itself does not enforce this.
module ticket_extraction_monitor_top (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [1:0]          in_operation,
  input  wire                 in_first_page,
  input  wire  [7:0]          in_status_byte_two,
  input  wire  [7:0]          in_status_byte_three,
  input  wire                 in_read_ok,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic                out_done_res,
  output logic [1:0]          out_outcome,
  output logic [2:0]          out_phase,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  tem_pkg::cfg_t cfg_extraction_timeout_ms
);
  import tem_pkg::*;

  logic    item_valid_r;
  item_t   item_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  cfg_t    timeout_r;
  logic    advance;

  assign advance   = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !item_valid_r || advance;
  assign cfg_ready = 1'b1;

  tem_next u_next (
    .item                  (item_r),
    .cur                   (state_r),
    .extraction_timeout_ms (timeout_r),
    .nxt                   (state_nxt),
    .res                   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= CFG_RESET;
    end else if (cfg_valid) begin
      timeout_r <= cfg_extraction_timeout_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{operation: in_operation, first_page: in_first_page,
                  status_byte_two: in_status_byte_two,
                  status_byte_three: in_status_byte_three, read_ok: in_read_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, elapsed: '0, limit: '0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_done_res = res_r.done_res;
  assign out_outcome  = res_r.outcome;
  assign out_phase    = res_r.phase;

endmodule
`default_nettype wire

FILE: dv/tb_ticket_extraction_monitor_top.sv
// self-checking testbench for the ticket extraction monitor top level
`timescale 1ns / 1ps
module tb_ticket_extraction_monitor_top;
  import tem_pkg::*;

  // operation code 3 carries no meaning and must be ignored
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam cfg_t TIMEOUT_MAX_MS = CFG_W'(86400000);

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_operation;
  logic       in_first_page;
  logic [7:0] in_status_byte_two;
  logic [7:0] in_status_byte_three;
  logic       in_read_ok;
  logic       out_valid;
  logic       out_ready;
  logic       out_done_res;
  logic [1:0] out_outcome;
  logic [2:0] out_phase;
  logic       cfg_valid;
  logic       cfg_ready;
  cfg_t       cfg_extraction_timeout_ms;

  ticket_extraction_monitor_top DUT (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .in_operation              (in_operation),
    .in_first_page             (in_first_page),
    .in_status_byte_two        (in_status_byte_two),
    .in_status_byte_three      (in_status_byte_three),
    .in_read_ok                (in_read_ok),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_done_res              (out_done_res),
    .out_outcome               (out_outcome),
    .out_phase                 (out_phase),
    .cfg_valid                 (cfg_valid),
    .cfg_ready                 (cfg_ready),
    .cfg_extraction_timeout_ms (cfg_extraction_timeout_ms)
  );

  // tracked copy of the monitor state
  logic [2:0] trk_phase;
  timer_t     trk_elapsed;
  timer_t     trk_limit;
  cfg_t       trk_timeout_ms;

  result_t pending_results[$];
  result_t want_r;
  int unsigned mismatch_count;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned sink_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("ticket_extraction_monitor_top regression: fail");
    $finish;
  end

  function automatic timer_t clamp_timeout(input cfg_t v);
    if (64'(v) > 64'(TIMER_MAX)) return TIMER_MAX;
    return timer_t'(v);
  endfunction

  function automatic void enter_phase(input logic [2:0] ph, input timer_t lim);
    trk_phase   = ph;
    trk_limit   = lim;
    trk_elapsed = '0;
  endfunction

  function automatic result_t finish_check(input logic [1:0] how);
    result_t r;
    trk_phase   = PH_IDLE;
    trk_elapsed = '0;
    r.done_res  = 1'b1;
    r.outcome   = how;
    r.phase     = PH_IDLE;
    return r;
  endfunction

  // next monitor result for one accepted item, updating the tracked state
  function automatic result_t predict_result(input item_t it);
    result_t r;
    logic    ticket;
    logic    spool;
    ticket = it.status_byte_two[TICKET_BIT];
    spool  = it.status_byte_three[SPOOL_BIT];
    r = '0;
    if (it.operation == OP_START) begin
      if (!it.read_ok) return finish_check(OUT_ERROR);
      if (it.first_page) enter_phase(PH_CHECK, clamp_timeout(trk_timeout_ms));
      else if (spool) enter_phase(PH_SPOOL, LIMIT_SPOOL_END);
      else enter_phase(PH_WAIT_SPOOL, LIMIT_WAIT_SPOOL);
    end else if (it.operation == OP_POLL && trk_phase != PH_IDLE) begin
      if (!it.read_ok) return finish_check(OUT_ERROR);
      case (trk_phase)
        PH_WAIT_SPOOL: begin
          if (spool) enter_phase(PH_SPOOL, LIMIT_SPOOL_END);
        end
        PH_SPOOL, PH_WAIT_SPOOL_END: begin
          // moving into wait spooling end keeps the running timer
          trk_phase = PH_WAIT_SPOOL_END;
          if (!spool) enter_phase(PH_WAIT_TICKET, LIMIT_WAIT_TICKET);
        end
        PH_WAIT_TICKET: begin
          if (ticket) enter_phase(PH_CHECK, clamp_timeout(trk_timeout_ms));
        end
        PH_CHECK: begin
          if (!ticket) return finish_check(OUT_EXTRACTED);
        end
        default: begin
          trk_phase   = PH_IDLE;
          trk_elapsed = '0;
          return r;
        end
      endcase
      if (trk_elapsed > trk_limit) begin
        if (trk_phase == PH_WAIT_SPOOL || trk_phase == PH_WAIT_TICKET) begin
          enter_phase(PH_CHECK, clamp_timeout(trk_timeout_ms));
        end else begin
          return finish_check(OUT_TIMEOUT);
        end
      end
    end else if (it.operation == OP_TICK && trk_phase != PH_IDLE) begin
      if (trk_elapsed != TIMER_MAX) trk_elapsed = trk_elapsed + TIMER_BITS'(1);
    end
    r.phase = trk_phase;
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch, expected %0d got %0d", $realtime, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with no item pending: done %0d outcome %0d phase %0d",
                   $realtime, out_done_res, out_outcome, out_phase);
      end else begin
        want_r = pending_results.pop_front();
        check_field("done_res", 32'(want_r.done_res), 32'(out_done_res));
        check_field("outcome", 32'(want_r.outcome), 32'(out_outcome));
        check_field("phase", 32'(want_r.phase), 32'(out_phase));
      end
    end
  end

  // result side: random stalls plus an optional long hold-off
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        out_ready <= 1'b0;
        sink_hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_item(input item_t it);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid             <= 1'b1;
    in_operation         <= it.operation;
    in_first_page        <= it.first_page;
    in_status_byte_two   <= it.status_byte_two;
    in_status_byte_three <= it.status_byte_three;
    in_read_ok           <= it.read_ok;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_result(it));
    @(negedge clk);
  endtask

  // stray status bits are random so that every bit toggles
  task automatic send_op(input logic [1:0] op, input logic first, input logic ticket,
                         input logic spool, input logic ok);
    item_t it;
    it.operation         = op;
    it.first_page        = first;
    it.status_byte_two   = 8'($urandom_range(255));
    it.status_byte_three = 8'($urandom_range(255));
    it.status_byte_two[TICKET_BIT]   = ticket;
    it.status_byte_three[SPOOL_BIT]  = spool;
    it.read_ok           = ok;
    send_item(it);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_op(OP_TICK, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [1:0]  op;
    pick = $urandom_range(99);
    if (pick < 12) op = OP_START;
    else if (pick < 57) op = OP_POLL;
    else if (pick < 95) op = OP_TICK;
    else op = OP_NONE;
    send_op(op, $urandom_range(9) < 4, 1'($urandom), 1'($urandom), $urandom_range(9) != 0);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_extraction_timeout(input cfg_t v);
    cfg_valid                 <= 1'b1;
    cfg_extraction_timeout_ms <= v;
    do @(posedge clk); while (!cfg_ready);
    trk_timeout_ms = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_directed_basics();
    item_t it;
    // idle: poll, tick, the unused code and a start with a read error leave the monitor idle
    send_op(OP_POLL, 1'b0, 1'b1, 1'b1, 1'b1);
    send_op(OP_POLL, 1'b1, 1'b0, 1'b0, 1'b0);
    send_op(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b1);
    send_op(OP_NONE, 1'b1, 1'b1, 1'b1, 1'b1);
    send_op(OP_START, 1'b1, 1'b1, 1'b1, 1'b0);
    // first page goes straight to the extraction check
    send_op(OP_START, 1'b1, 1'b0, 1'b0, 1'b1);
    send_op(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b1);
    send_op(OP_POLL, 1'b0, 1'b0, 1'b1, 1'b1);
    // walk from spooling through every later phase, ended by a read error
    send_op(OP_START, 1'b0, 1'b0, 1'b1, 1'b1);
    send_op(OP_POLL, 1'b0, 1'b0, 1'b1, 1'b1);
    send_op(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b1);
    send_op(OP_POLL, 1'b0, 1'b0, 1'b0, 1'b1);
    send_op(OP_POLL, 1'b0, 1'b1, 1'b1, 1'b1);
    send_op(OP_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_op(OP_POLL, 1'b0, 1'b1, 1'b1, 1'b0);
    // stray bits all set with the meaningful ones clear, then every bit set
    it = '{operation: OP_START, first_page: 1'b0, status_byte_two: 8'hDF,
           status_byte_three: 8'hFB, read_ok: 1'b1};
    send_item(it);
    it.operation = OP_POLL;
    send_item(it);
    it.status_byte_two   = 8'hFF;
    it.status_byte_three = 8'hFF;
    send_item(it);
    // restart while running
    it = '{operation: OP_START, first_page: 1'b1, status_byte_two: 8'h00,
           status_byte_three: 8'h00, read_ok: 1'b1};
    send_item(it);
    it.operation = OP_POLL;
    send_item(it);
    wait_results_drained();
  endtask

  task automatic test_phase_timeouts();
    // wait spooling: exactly at the limit holds, one past falls through
    send_op(OP_START, 1'b0, 1'b0, 1'b0, 1'b1);
    send_ticks(1000);
    send_op(OP_POLL, 1'b0, 1'b0, 1'b0, 1'b1);
    send_ticks(1);
    send_op(OP_POLL, 1'b0, 1'b0, 1'b0, 1'b1);
    send_op(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b1);
    send_op(OP_POLL, 1'b0, 1'b0, 1'b0, 1'b1);
    // wait ticket falls through to the extraction check
    send_op(OP_START, 1'b0, 1'b0, 1'b1, 1'b1);
    send_op(OP_POLL, 1'b0, 1'b0, 1'b0, 1'b1);
    send_ticks(5001);
    send_op(OP_POLL, 1'b0, 1'b0, 1'b1, 1'b1);
    // spooling ends with a timeout
    send_op(OP_START, 1'b0, 1'b0, 1'b1, 1'b1);
    send_ticks(60001);
    send_op(OP_POLL, 1'b0, 1'b0, 1'b1, 1'b1);
    // extraction check at the reset timeout
    send_op(OP_START, 1'b1, 1'b1, 1'b1, 1'b1);
    send_ticks(5001);
    send_op(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_timeout_register();
    write_extraction_timeout('0);
    send_op(OP_START, 1'b1, 1'b1, 1'b0, 1'b1);
    send_op(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b1);
    send_ticks(1);
    send_op(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b1);
    wait_results_drained();
    write_extraction_timeout(TIMEOUT_MAX_MS);
    send_op(OP_START, 1'b1, 1'b1, 1'b0, 1'b1);
    send_ticks(200);
    send_op(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b1);
    send_op(OP_POLL, 1'b0, 1'b0, 1'b0, 1'b1);
    wait_results_drained();
    write_extraction_timeout(CFG_W'(7));
    send_op(OP_START, 1'b1, 1'b1, 1'b0, 1'b1);
    send_ticks(8);
    send_op(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    sink_hold_cycles = 80;
    repeat (40) send_random_item();
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    for (int i = 0; i < 450; i++) begin
      if (i == 0) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (i == 120) begin
        src_idle_pct  = 26;
        sink_idle_pct = 26;
      end
      if (i % 90 == 89) begin
        wait_results_drained();
        case ($urandom_range(3))
          0: write_extraction_timeout('0);
          1: write_extraction_timeout(CFG_W'($urandom_range(40, 1)));
          2: write_extraction_timeout(TIMEOUT_MAX_MS);
          default: write_extraction_timeout(CFG_W'($urandom_range(86400000)));
        endcase
      end
      pick = $urandom_range(199);
      if (pick < 4) begin
        // long waits around the wait spooling and wait ticket limits
        send_op(OP_START, 1'b0, 1'($urandom), 1'($urandom), 1'b1);
        if (pick == 0) send_op(OP_POLL, 1'b0, 1'b0, 1'b0, 1'b1);
        send_ticks(pick == 0 ? $urandom_range(5005, 4995) : $urandom_range(1005, 995));
        send_op(OP_POLL, 1'b0, 1'($urandom), 1'($urandom), 1'b1);
      end else begin
        send_random_item();
      end
    end
    wait_results_drained();
  endtask

  initial begin
    rst_n                     = 1'b0;
    in_valid                  = 1'b0;
    in_operation              = OP_START;
    in_first_page             = 1'b0;
    in_status_byte_two        = '0;
    in_status_byte_three      = '0;
    in_read_ok                = 1'b0;
    cfg_valid                 = 1'b0;
    cfg_extraction_timeout_ms = '0;
    mismatch_count            = 0;
    src_idle_pct              = 26;
    sink_idle_pct             = 26;
    sink_hold_cycles          = 0;
    trk_phase                 = PH_IDLE;
    trk_elapsed               = '0;
    trk_limit                 = '0;
    trk_timeout_ms            = CFG_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_basics();
    test_phase_timeouts();
    test_timeout_register();
    test_backpressure();
    test_random_traffic();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ticket_extraction_monitor_top regression: pass");
    end else begin
      $display("ticket_extraction_monitor_top regression: fail");
    end
    $finish;
  end

endmodule
